>>> rtl/rdac_pkg.sv
// ============================================================================
// rdac_pkg: shared types and constants for the receive dedup/ack classifier
// Field widths, flag bit positions, result action codes and sequencer states.
// ============================================================================
package rdac_pkg;

  localparam int ADDR_W     = 32;
  localparam int SEQ_W      = 16;
  localparam int FLAGS_W    = 4;
  localparam int PEER_IDX_W = 4;
  localparam int ACTION_W   = 2;

  // flag bit positions in the header flags field
  localparam int FLAG_ACK    = 0;
  localparam int FLAG_BCAST  = 1;
  localparam int FLAG_RESET  = 2;
  localparam int FLAG_ACKREQ = 3;

  localparam logic [SEQ_W-1:0] HIST_INIT = 16'h0101;
  localparam logic [SEQ_W-1:0] HIST_ZERO = 16'h0000;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ACK   = 2'd0,
    ACT_BCAST = 2'd1,
    ACT_DUP   = 2'd2,
    ACT_NEW   = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_ALLOC,
    ST_CLASS,
    ST_ROW_CLR,
    ST_WAIT_REM,
    ST_HIST_CMP
  } state_t;

endpackage

>>> rtl/rdac_ram.sv
// ============================================================================
// rdac_ram: generic single-write, single-read RAM
// One write port and one read port; read data registered.
// ============================================================================
module rdac_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/rdac_rem.sv
// ============================================================================
// rdac_rem: remainder by a constant
// Quotient by reciprocal multiply, then a multiply-subtract for the remainder;
// one shared multiplier, one step a cycle; done rises with the registered remainder.
// ============================================================================
module rdac_rem #(
  parameter int DIVISOR = 128
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [rdac_pkg::SEQ_W-1:0]    dividend,
  output logic                          done,
  output logic [$clog2(DIVISOR)-1:0]    rem
);

  localparam int SW    = rdac_pkg::SEQ_W;
  localparam int REM_W = $clog2(DIVISOR);
  localparam int MW    = SW + 1;          // reciprocal width
  localparam int SH    = SW + REM_W;      // reciprocal scale
  localparam int PRW   = SW + MW;         // product width
  // ceil(2**SH / DIVISOR): exact quotient for every SW-bit dividend
  localparam logic [MW-1:0] RECIP =
    MW'(((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

  logic [SW-1:0]    x_r, x_nxt;
  logic [SW-1:0]    q_r, q_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic             stp_r, stp_nxt;
  logic             run_r, run_nxt;
  logic             done_r, done_nxt;
  logic [SW-1:0]    opa;
  logic [MW-1:0]    opb;
  logic [PRW-1:0]   prod;
  logic [SW-1:0]    diff;

  // shared multiplier: x * recip first, then q * divisor
  assign opa  = stp_r ? q_r : x_r;
  assign opb  = stp_r ? MW'(DIVISOR) : RECIP;
  assign prod = opa * opb;
  assign diff = x_r - prod[SW-1:0];

  always_comb begin
    x_nxt    = x_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    stp_nxt  = stp_r;
    run_nxt  = run_r;
    done_nxt = done_r;
    if (start) begin
      x_nxt    = dividend;
      stp_nxt  = 1'b0;
      run_nxt  = 1'b1;
      done_nxt = 1'b0;
    end else if (run_r) begin
      if (!stp_r) begin
        q_nxt   = SW'(prod >> SH);
        stp_nxt = 1'b1;
      end else begin
        rem_nxt  = diff[REM_W-1:0];
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    x_r   <= x_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    stp_r <= stp_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

>>> rtl/receive_dedup_ack_classifier.sv
// ============================================================================
// receive_dedup_ack_classifier: receive-side duplicate filter and ack sorter
// Classifies one received packet header per transaction; peer table lookup,
// per-peer sequence history and ack decision, one result per transaction.
// ============================================================================
// A header transaction is taken when start is high and busy is low; exactly
// one result follows, shown for a single cycle with out_valid, and the
// receiver cannot stall it. busy drops in the cycle that carries the result.
// Broadcast packets (without the ack flag) return their result in the cycle
// after the transaction and busy never rises. Every other packet scans the
// peer address table, one RAM read and one compare per entry looked at.
// A normal packet from a known peer then goes to classify, history read and
// compare; a new peer takes one more read after the slots in use, an
// allocate step, then classify, history read and compare. Ack packets skip
// the history and answer from classify. An unknown peer with the table full
// is answered from classify after a scan of every slot. Sequence reset
// packets sweep the peer's history row instead, zeroing all HISTORY_SLOTS
// entries. The history slot (seq mod HISTORY_SLOTS) comes from a reciprocal
// multiply on a shared multiplier, always ready before classify ends. After
// reset the block clears the whole history memory to 0x0101, busy all the
// while, before the first transaction.
// ============================================================================
module receive_dedup_ack_classifier #(
  parameter int MAX_PEERS     = 16,
  parameter int HISTORY_SLOTS = 128
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [rdac_pkg::ADDR_W-1:0]       in_peer_addr,
  input  logic [rdac_pkg::SEQ_W-1:0]        in_seq,
  input  logic [rdac_pkg::FLAGS_W-1:0]      in_flags,
  output logic                              out_valid,
  output logic [rdac_pkg::ACTION_W-1:0]     out_action,
  output logic                              out_send_ack,
  output logic [rdac_pkg::SEQ_W-1:0]        out_ack_seq,
  output logic [rdac_pkg::PEER_IDX_W-1:0]   out_peer_index,
  output logic                              out_release_outstanding,
  output logic                              out_peer_table_full
);

  localparam int AW     = rdac_pkg::ADDR_W;
  localparam int SW     = rdac_pkg::SEQ_W;
  localparam int FW     = rdac_pkg::FLAGS_W;
  localparam int PIW    = rdac_pkg::PEER_IDX_W;
  localparam int PW     = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;  // slot index
  localparam int CW     = $clog2(MAX_PEERS + 1);                    // peer count
  localparam int HW     = $clog2(HISTORY_SLOTS);                    // row offset
  localparam int HAW    = PW + HW;
  localparam int HDEPTH = MAX_PEERS << HW;                          // row stride 2**HW

  rdac_pkg::state_t  state_r, state_nxt;

  // latched header
  logic [AW-1:0]     addr_r, addr_nxt;
  logic [SW-1:0]     seq_r, seq_nxt;
  logic [FW-1:0]     flags_r, flags_nxt;

  // lookup and sweep control
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;     // slots handed out so far
  logic [PW-1:0]     slot_r, slot_nxt;
  logic              full_r, full_nxt;
  logic [HW-1:0]     off_r, off_nxt;
  logic [HAW-1:0]    clr_r, clr_nxt;

  // result registers
  logic              vld_r, vld_nxt;
  rdac_pkg::action_t act_r, act_nxt;
  logic              sack_r, sack_nxt;
  logic [SW-1:0]     aseq_r, aseq_nxt;
  logic [PIW-1:0]    pidx_r, pidx_nxt;
  logic              rel_r, rel_nxt;
  logic              pfull_r, pfull_nxt;

  // memories
  logic              p_we;
  logic [AW-1:0]     p_rdata;
  logic              h_we;
  logic [HAW-1:0]    h_waddr;
  logic [SW-1:0]     h_wdata;
  logic [SW-1:0]     h_rdata;
  logic [HAW-1:0]    h_raddr;

  // remainder unit
  logic              accept;
  logic              rem_done;
  logic [HW-1:0]     rem_val;

  assign busy    = (state_r != rdac_pkg::ST_IDLE);
  assign accept  = start && !busy;
  assign h_raddr = {slot_r, rem_val};

  // peer address table: written on allocate, read at the scan index
  rdac_ram #(
    .WIDTH (AW),
    .DEPTH (MAX_PEERS)
  ) u_peer_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (cnt_r[PW-1:0]),
    .wdata (addr_r),
    .raddr (idx_r[PW-1:0]),
    .rdata (p_rdata)
  );

  // sequence history, one row per peer
  rdac_ram #(
    .WIDTH (SW),
    .DEPTH (HDEPTH)
  ) u_hist_ram (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  // seq mod HISTORY_SLOTS, started on every transaction
  rdac_rem #(
    .DIVISOR (HISTORY_SLOTS)
  ) u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept),
    .dividend (in_seq),
    .done     (rem_done),
    .rem      (rem_val)
  );

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    addr_nxt  = addr_r;
    seq_nxt   = seq_r;
    flags_nxt = flags_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    slot_nxt  = slot_r;
    full_nxt  = full_r;
    off_nxt   = off_r;
    clr_nxt   = clr_r;

    vld_nxt   = 1'b0;
    act_nxt   = act_r;
    sack_nxt  = sack_r;
    aseq_nxt  = aseq_r;
    pidx_nxt  = pidx_r;
    rel_nxt   = rel_r;
    pfull_nxt = pfull_r;

    p_we    = 1'b0;
    h_we    = 1'b0;
    h_waddr = {slot_r, off_r};
    h_wdata = rdac_pkg::HIST_ZERO;

    unique case (state_r)
      rdac_pkg::ST_CLEAR: begin
        // post-reset sweep: every history entry to its initial value
        h_we    = 1'b1;
        h_waddr = clr_r;
        h_wdata = rdac_pkg::HIST_INIT;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == HAW'(HDEPTH - 1)) begin
          state_nxt = rdac_pkg::ST_IDLE;
        end
      end

      rdac_pkg::ST_IDLE: begin
        if (start) begin
          addr_nxt  = in_peer_addr;
          seq_nxt   = in_seq;
          flags_nxt = in_flags;
          idx_nxt   = '0;
          full_nxt  = 1'b0;
          if (!in_flags[rdac_pkg::FLAG_ACK] && in_flags[rdac_pkg::FLAG_BCAST]) begin
            // broadcast: no lookup, answer right away
            vld_nxt   = 1'b1;
            act_nxt   = rdac_pkg::ACT_BCAST;
            sack_nxt  = 1'b0;
            aseq_nxt  = in_seq;
            pidx_nxt  = '0;
            rel_nxt   = 1'b0;
            pfull_nxt = 1'b0;
          end else begin
            state_nxt = rdac_pkg::ST_SCAN_RD;
          end
        end
      end

      rdac_pkg::ST_SCAN_RD: begin
        // read issued at idx_r; entries past the count were never written
        if (idx_r == cnt_r) begin
          state_nxt = rdac_pkg::ST_ALLOC;
        end else begin
          state_nxt = rdac_pkg::ST_SCAN_CMP;
        end
      end

      rdac_pkg::ST_SCAN_CMP: begin
        if (p_rdata == addr_r) begin
          slot_nxt  = idx_r[PW-1:0];
          state_nxt = rdac_pkg::ST_CLASS;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = rdac_pkg::ST_SCAN_RD;
        end
      end

      rdac_pkg::ST_ALLOC: begin
        if (cnt_r != CW'(MAX_PEERS)) begin
          p_we     = 1'b1;
          slot_nxt = cnt_r[PW-1:0];
          cnt_nxt  = cnt_r + 1'b1;
        end else begin
          full_nxt = 1'b1;
        end
        state_nxt = rdac_pkg::ST_CLASS;
      end

      rdac_pkg::ST_CLASS: begin
        off_nxt  = '0;
        aseq_nxt = seq_r;
        priority if (flags_r[rdac_pkg::FLAG_ACK]) begin
          vld_nxt   = 1'b1;
          act_nxt   = rdac_pkg::ACT_ACK;
          sack_nxt  = 1'b0;
          pidx_nxt  = full_r ? '0 : PIW'(slot_r);
          rel_nxt   = !full_r;
          pfull_nxt = full_r;
          state_nxt = rdac_pkg::ST_IDLE;
        end else if (full_r) begin
          // unknown peer, no room: pass the packet, history untouched
          vld_nxt   = 1'b1;
          act_nxt   = rdac_pkg::ACT_NEW;
          sack_nxt  = flags_r[rdac_pkg::FLAG_ACKREQ];
          pidx_nxt  = '0;
          rel_nxt   = 1'b0;
          pfull_nxt = 1'b1;
          state_nxt = rdac_pkg::ST_IDLE;
        end else if (flags_r[rdac_pkg::FLAG_RESET]) begin
          state_nxt = rdac_pkg::ST_ROW_CLR;
        end else begin
          state_nxt = rdac_pkg::ST_WAIT_REM;
        end
      end

      rdac_pkg::ST_ROW_CLR: begin
        h_we    = 1'b1;
        h_waddr = {slot_r, off_r};
        h_wdata = rdac_pkg::HIST_ZERO;
        off_nxt = off_r + 1'b1;
        if (off_r == HW'(HISTORY_SLOTS - 1)) begin
          vld_nxt   = 1'b1;
          act_nxt   = rdac_pkg::ACT_NEW;
          sack_nxt  = flags_r[rdac_pkg::FLAG_ACKREQ];
          pidx_nxt  = PIW'(slot_r);
          rel_nxt   = 1'b0;
          pfull_nxt = 1'b0;
          state_nxt = rdac_pkg::ST_IDLE;
        end
      end

      rdac_pkg::ST_WAIT_REM: begin
        // history read at {slot, seq mod slots} goes out on leaving
        if (rem_done) begin
          state_nxt = rdac_pkg::ST_HIST_CMP;
        end
      end

      rdac_pkg::ST_HIST_CMP: begin
        vld_nxt   = 1'b1;
        sack_nxt  = flags_r[rdac_pkg::FLAG_ACKREQ];
        pidx_nxt  = PIW'(slot_r);
        rel_nxt   = 1'b0;
        pfull_nxt = 1'b0;
        if (h_rdata == seq_r) begin
          act_nxt = rdac_pkg::ACT_DUP;
        end else begin
          h_we    = 1'b1;
          h_waddr = h_raddr;
          h_wdata = seq_r;
          act_nxt = rdac_pkg::ACT_NEW;
        end
        state_nxt = rdac_pkg::ST_IDLE;
      end

      default: begin
        state_nxt = rdac_pkg::ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rdac_pkg::ST_CLEAR;
      cnt_r   <= '0;
      clr_r   <= '0;
      vld_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      clr_r   <= clr_nxt;
      vld_r   <= vld_nxt;
    end
    addr_r  <= addr_nxt;
    seq_r   <= seq_nxt;
    flags_r <= flags_nxt;
    idx_r   <= idx_nxt;
    slot_r  <= slot_nxt;
    full_r  <= full_nxt;
    off_r   <= off_nxt;
    act_r   <= act_nxt;
    sack_r  <= sack_nxt;
    aseq_r  <= aseq_nxt;
    pidx_r  <= pidx_nxt;
    rel_r   <= rel_nxt;
    pfull_r <= pfull_nxt;
  end

  assign out_valid               = vld_r;
  assign out_action              = act_r;
  assign out_send_ack            = sack_r;
  assign out_ack_seq             = aseq_r;
  assign out_peer_index          = pidx_r;
  assign out_release_outstanding = rel_r;
  assign out_peer_table_full     = pfull_r;

endmodule

>>> rtl/rdac_checker.sv
// ============================================================================
// rdac_checker: port-level checks for the receive dedup/ack classifier
// Watches the top-level ports only; attached by bind.
// ============================================================================
module rdac_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input logic [rdac_pkg::ADDR_W-1:0]       in_peer_addr,
  input logic [rdac_pkg::SEQ_W-1:0]        in_seq,
  input logic [rdac_pkg::FLAGS_W-1:0]      in_flags,
  input logic                              out_valid,
  input logic [rdac_pkg::ACTION_W-1:0]     out_action,
  input logic                              out_send_ack,
  input logic [rdac_pkg::SEQ_W-1:0]        out_ack_seq,
  input logic [rdac_pkg::PEER_IDX_W-1:0]   out_peer_index,
  input logic                              out_release_outstanding,
  input logic                              out_peer_table_full
);

  // history sweep follows reset, so no transaction right after it
  a_busy_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> busy)
    else $error("not busy right after reset");

  // broadcast transaction answers in the next cycle, echoing its seq
  a_bcast_next: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_flags[rdac_pkg::FLAG_BCAST] && !in_flags[rdac_pkg::FLAG_ACK])
    |=> (out_valid && out_action == rdac_pkg::ACT_BCAST && out_ack_seq == $past(in_seq)
         && out_peer_index == '0 && !out_send_ack && !out_release_outstanding))
    else $error("broadcast result wrong or late");

  // a full table never yields a slot or a release
  a_full_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_peer_table_full)
    |-> (out_peer_index == '0 && !out_release_outstanding))
    else $error("slot or release with full peer table");

  // release and ack send only on the matching action codes
  a_release_ack: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_release_outstanding || out_send_ack))
    |-> ((out_release_outstanding && out_action == rdac_pkg::ACT_ACK && !out_send_ack)
         || (out_send_ack && !out_release_outstanding
             && (out_action == rdac_pkg::ACT_DUP || out_action == rdac_pkg::ACT_NEW))))
    else $error("release/ack flag with wrong action");

  // a result only ever follows an accepted transaction or ongoing work
  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !$past(!rst_n)) |-> ($past(busy) || $past(start)))
    else $error("result without a transaction");

endmodule

bind receive_dedup_ack_classifier rdac_checker u_rdac_checker (.*);

>>> test/rdac_classify_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// rdac_classify_checker: result checker for the receive dedup/ack classifier
// Mirrors the peer table and sequence history, predicts one verdict per
// accepted header and compares every strobed result with the oldest one.
// ============================================================================
module rdac_classify_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic                              busy,
  input  logic [rdac_pkg::ADDR_W-1:0]       in_peer_addr,
  input  logic [rdac_pkg::SEQ_W-1:0]        in_seq,
  input  logic [rdac_pkg::FLAGS_W-1:0]      in_flags,
  input  logic                              out_valid,
  input  logic [rdac_pkg::ACTION_W-1:0]     out_action,
  input  logic                              out_send_ack,
  input  logic [rdac_pkg::SEQ_W-1:0]        out_ack_seq,
  input  logic [rdac_pkg::PEER_IDX_W-1:0]   out_peer_index,
  input  logic                              out_release_outstanding,
  input  logic                              out_peer_table_full,
  output int                                mismatch_count,
  output int                                pending_count
);
  import rdac_pkg::*;

  localparam int NUM_PEERS  = 16;
  localparam int HIST_SLOTS = 128;

  typedef struct packed {
    action_t               action;
    logic                  send_ack;
    logic [SEQ_W-1:0]      ack_seq;
    logic [PEER_IDX_W-1:0] peer_index;
    logic                  release_out;
    logic                  table_full;
  } verdict_t;

  logic [ADDR_W-1:0] peer_addr_tbl [NUM_PEERS];
  logic              peer_used [NUM_PEERS];
  int                peers_handed_out;
  logic [SEQ_W-1:0]  seq_history [NUM_PEERS][HIST_SLOTS];
  verdict_t          expected_verdicts [$];
  int                errs;

  assign mismatch_count = errs;

  initial pending_count = 0;

  // match a known peer, else hand out the next slot; 0 when the table is full
  function automatic bit lookup_peer(input logic [ADDR_W-1:0] addr, output int slot);
    int i;
    slot = 0;
    for (i = 0; i < NUM_PEERS; i++) begin
      if (peer_used[i] && peer_addr_tbl[i] == addr) begin
        slot = i;
        return 1'b1;
      end
    end
    if (peers_handed_out < NUM_PEERS) begin
      slot = peers_handed_out;
      peer_addr_tbl[slot] = addr;
      peer_used[slot] = 1'b1;
      peers_handed_out++;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic verdict_t classify_header(input logic [ADDR_W-1:0] addr,
                                               input logic [SEQ_W-1:0] seq,
                                               input logic [FLAGS_W-1:0] flags);
    verdict_t v;
    int       slot;
    int       i;
    int       hidx;
    bit       found;
    v.action      = ACT_NEW;
    v.send_ack    = 1'b0;
    v.ack_seq     = seq;
    v.peer_index  = '0;
    v.release_out = 1'b0;
    v.table_full  = 1'b0;
    if (flags[FLAG_ACK]) begin
      // ack packets still allocate a slot for a new peer
      v.action = ACT_ACK;
      found = lookup_peer(addr, slot);
      if (found) begin
        v.release_out = 1'b1;
        v.peer_index  = slot[PEER_IDX_W-1:0];
      end else begin
        v.table_full = 1'b1;
      end
    end else if (flags[FLAG_BCAST]) begin
      v.action = ACT_BCAST;
    end else begin
      found = lookup_peer(addr, slot);
      if (!found) begin
        v.table_full = 1'b1;
      end else begin
        v.peer_index = slot[PEER_IDX_W-1:0];
        if (flags[FLAG_RESET]) begin
          for (i = 0; i < HIST_SLOTS; i++) seq_history[slot][i] = HIST_ZERO;
        end else begin
          hidx = int'(seq) % HIST_SLOTS;
          if (seq_history[slot][hidx] == seq) v.action = ACT_DUP;
          else seq_history[slot][hidx] = seq;
        end
      end
      v.send_ack = flags[FLAG_ACKREQ];
    end
    return v;
  endfunction

  task automatic report_miss(input string what, input verdict_t want, input verdict_t got);
    if (errs < 10)
      $display("%0t %s: exp act=%0d ack=%0d seq=%h idx=%0d rel=%0d full=%0d | got act=%0d ack=%0d seq=%h idx=%0d rel=%0d full=%0d",
               $time, what, want.action, want.send_ack, want.ack_seq, want.peer_index,
               want.release_out, want.table_full, got.action, got.send_ack, got.ack_seq,
               got.peer_index, got.release_out, got.table_full);
    errs++;
  endtask

  always @(posedge clk) begin : watch
    verdict_t got;
    verdict_t want;
    int p;
    int s;
    if (!rst_n) begin
      for (p = 0; p < NUM_PEERS; p++) begin
        peer_used[p] = 1'b0;
        for (s = 0; s < HIST_SLOTS; s++) seq_history[p][s] = HIST_INIT;
      end
      peers_handed_out = 0;
      expected_verdicts.delete();
      errs = 0;
    end else begin
      // results first: a result never belongs to a header taken at the same edge
      if (out_valid === 1'b1) begin
        got.action      = action_t'(out_action);
        got.send_ack    = out_send_ack;
        got.ack_seq     = out_ack_seq;
        got.peer_index  = out_peer_index;
        got.release_out = out_release_outstanding;
        got.table_full  = out_peer_table_full;
        if (expected_verdicts.size() == 0) begin
          report_miss("unexpected result", '0, got);
        end else begin
          want = expected_verdicts.pop_front();
          if (got.action !== want.action || got.send_ack !== want.send_ack ||
              got.ack_seq !== want.ack_seq || got.peer_index !== want.peer_index ||
              got.release_out !== want.release_out || got.table_full !== want.table_full)
            report_miss("result mismatch", want, got);
        end
      end
      if (start === 1'b1 && busy === 1'b0)
        expected_verdicts.push_back(classify_header(in_peer_addr, in_seq, in_flags));
    end
    pending_count <= expected_verdicts.size();
  end

endmodule

>>> test/tb_receive_dedup_ack_classifier.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_receive_dedup_ack_classifier: testbench for the receive dedup classifier
// Drives directed and random packet headers through the command handshake in
// several idle phases; a side checker predicts and compares every result.
// ============================================================================
module tb_receive_dedup_ack_classifier;
  import rdac_pkg::*;

  localparam int RESET_CYCLES    = 9;
  localparam int ITEMS_PER_PHASE = 350;
  localparam int NUM_PHASES      = 3;
  localparam int POOL_SIZE       = 20;
  localparam int DRAIN_LIMIT     = 20000;
  // longest single transaction is a history row sweep plus a full peer scan
  localparam int SETTLE_CYCLES   = 200;

  // flag masks built from the package bit positions
  localparam logic [FLAGS_W-1:0] F_ACK    = FLAGS_W'(1 << FLAG_ACK);
  localparam logic [FLAGS_W-1:0] F_BCAST  = FLAGS_W'(1 << FLAG_BCAST);
  localparam logic [FLAGS_W-1:0] F_RESET  = FLAGS_W'(1 << FLAG_RESET);
  localparam logic [FLAGS_W-1:0] F_ACKREQ = FLAGS_W'(1 << FLAG_ACKREQ);

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [ADDR_W-1:0]     in_peer_addr;
  logic [SEQ_W-1:0]      in_seq;
  logic [FLAGS_W-1:0]    in_flags;
  logic                  out_valid;
  logic [ACTION_W-1:0]   out_action;
  logic                  out_send_ack;
  logic [SEQ_W-1:0]      out_ack_seq;
  logic [PEER_IDX_W-1:0] out_peer_index;
  logic                  out_release_outstanding;
  logic                  out_peer_table_full;
  int                    mismatch_count;
  int                    pending_count;

  // stimulus knobs
  int                    idle_pct;
  bit                    no_idle;
  logic [ADDR_W-1:0]     addr_pool [POOL_SIZE];

  always #5 clk = ~clk;

  receive_dedup_ack_classifier dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .start                   (start),
    .busy                    (busy),
    .in_peer_addr            (in_peer_addr),
    .in_seq                  (in_seq),
    .in_flags                (in_flags),
    .out_valid               (out_valid),
    .out_action              (out_action),
    .out_send_ack            (out_send_ack),
    .out_ack_seq             (out_ack_seq),
    .out_peer_index          (out_peer_index),
    .out_release_outstanding (out_release_outstanding),
    .out_peer_table_full     (out_peer_table_full)
  );

  rdac_classify_checker u_checker (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .start                   (start),
    .busy                    (busy),
    .in_peer_addr            (in_peer_addr),
    .in_seq                  (in_seq),
    .in_flags                (in_flags),
    .out_valid               (out_valid),
    .out_action              (out_action),
    .out_send_ack            (out_send_ack),
    .out_ack_seq             (out_ack_seq),
    .out_peer_index          (out_peer_index),
    .out_release_outstanding (out_release_outstanding),
    .out_peer_table_full     (out_peer_table_full),
    .mismatch_count          (mismatch_count),
    .pending_count           (pending_count)
  );

  // hard stop well beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("FAIL receive_dedup_ack_classifier");
    $finish;
  end

  // One header transaction. Idle cycles drop start first; start is only
  // ever assigned once per edge, so back-to-back transactions keep it high.
  task automatic send_header(input logic [ADDR_W-1:0] addr, input logic [SEQ_W-1:0] seq,
                             input logic [FLAGS_W-1:0] flags);
    if (!no_idle) begin
      while ($urandom_range(0, 99) < idle_pct) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start        <= 1'b1;
    in_peer_addr <= addr;
    in_seq       <= seq;
    in_flags     <= flags;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  // Mostly well-formed traffic from a small peer pool with sequence numbers
  // in a narrow window, so duplicates and slot collisions are common.
  // Pool entries past the first 16, plus fully random addresses, run the
  // table into its full state.
  task automatic random_header();
    logic [ADDR_W-1:0]  addr;
    logic [SEQ_W-1:0]   seq;
    logic [FLAGS_W-1:0] flags;
    int                 r;
    r = $urandom_range(0, 99);
    if (r < 80) addr = addr_pool[$urandom_range(0, 15)];
    else if (r < 90) addr = addr_pool[$urandom_range(16, POOL_SIZE - 1)];
    else addr = $urandom;

    r = $urandom_range(0, 99);
    if (r < 45) seq = SEQ_W'($urandom_range(0, 63));
    else if (r < 70) seq = SEQ_W'($urandom_range(0, 3) * 128 + $urandom_range(0, 63));
    else seq = SEQ_W'($urandom_range(0, 65535));

    r = $urandom_range(0, 99);
    if (r < 55) begin
      flags = $urandom_range(0, 1) ? F_ACKREQ : '0;
    end else if (r < 70) begin
      flags = F_ACK | (FLAGS_W'($urandom_range(0, 7)) << 1);
    end else if (r < 80) begin
      flags = F_BCAST | ($urandom_range(0, 1) ? F_RESET : '0)
                      | ($urandom_range(0, 1) ? F_ACKREQ : '0);
    end else if (r < 84) begin
      flags = F_RESET | ($urandom_range(0, 1) ? F_ACKREQ : '0);
    end else begin
      flags = FLAGS_W'($urandom_range(0, 15));
    end
    send_header(addr, seq, flags);
  endtask

  initial begin : stimulus
    int phase_idle [NUM_PHASES];
    int phase;
    int n;
    int waited;
    phase_idle[0] = 0;
    phase_idle[1] = 88;
    phase_idle[2] = 27;

    addr_pool[0] = '0;
    addr_pool[1] = '1;
    for (n = 2; n < POOL_SIZE; n++) addr_pool[n] = $urandom;

    rst_n        <= 1'b0;
    start        <= 1'b0;
    in_peer_addr <= '0;
    in_seq       <= '0;
    in_flags     <= '0;
    idle_pct     = 0;
    no_idle      = 1'b1;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // ---- directed part ----
    // field extremes and first duplicate hits
    send_header(addr_pool[0], 16'h0000, '0);
    send_header(addr_pool[0], 16'h0000, '0);
    send_header(addr_pool[1], 16'hFFFF, F_ACKREQ);
    send_header(addr_pool[1], 16'hFFFF, F_ACKREQ);
    // fresh history matches its reset pattern
    send_header(addr_pool[2], HIST_INIT, F_ACKREQ);
    // same slot, other value, then the first value again
    send_header(addr_pool[2], 16'h0181, '0);
    send_header(addr_pool[2], HIST_INIT, '0);
    // broadcast: no lookup, no ack even when asked
    send_header(addr_pool[3], 16'h1234, F_BCAST | F_ACKREQ);
    // ack from a known peer, then from a new one (allocates)
    send_header(addr_pool[0], 16'h0000, F_ACK);
    send_header(addr_pool[3], 16'h0005, F_ACK | F_ACKREQ);
    // sequence reset zeroes the row: seq 0 becomes a duplicate
    send_header(addr_pool[0], 16'h0007, F_RESET | F_ACKREQ);
    send_header(addr_pool[0], 16'h0000, '0);
    send_header(addr_pool[0], 16'h0080, F_ACKREQ);
    send_header(addr_pool[0], 16'h0080, F_ACKREQ);
    // several flags set: priority ack > broadcast > reset
    send_header(addr_pool[1], 16'h8000, F_ACK | F_BCAST | F_RESET | F_ACKREQ);
    send_header(addr_pool[1], 16'h7FFF, F_BCAST | F_RESET);
    send_header(addr_pool[4], 16'h00FF, F_ACK | F_RESET);
    send_header(addr_pool[4], 16'h5555, F_RESET | F_BCAST | F_ACKREQ);
    send_header(addr_pool[4], 16'hAAAA, '0);

    // ---- random part, one block per idle phase ----
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      idle_pct = phase_idle[phase];
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        // short bursts with no gaps inside every phase
        no_idle = (n % 64) < 10;
        random_header();
      end
    end

    start <= 1'b0;

    // drain: every expected result must show up
    @(posedge clk);
    waited = 0;
    while (pending_count != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_count == 0) begin
      $display("PASS receive_dedup_ack_classifier");
    end else begin
      $display("FAIL receive_dedup_ack_classifier");
    end
    $finish;
  end

endmodule
